@@ rtl/cdbt_pkg.sv @@
// ----------------------------------------------------------------------------
// cdbt_pkg
// types, constants and helpers shared by the cpu deadline tracker modules
// ----------------------------------------------------------------------------
`default_nettype none
package cdbt_pkg;
	localparam int unsigned NUM_CPUS_DEF = 64;
	localparam int unsigned DL_W = 64;
	localparam int unsigned CPU_W = 6;
	localparam int unsigned MASK_W = 64;

	typedef enum logic [1:0] {
		KIND_BUSY = 2'd0,
		KIND_FREE = 2'd1,
		KIND_PUSH = 2'd2,
		KIND_PULL = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [CPU_W-1:0]  cpu_index;
		logic [DL_W-1:0]   deadline;
		logic [MASK_W-1:0] allowed_mask;
		logic [MASK_W-1:0] active_mask;
		logic              want_mask;
		logic              cpu_ok;
	} cmd_t;

	// b ranks strictly better than a
	function automatic logic ranks_worse(input logic prefer_later,
			input logic [DL_W-1:0] a, input logic [DL_W-1:0] b);
		logic [DL_W-1:0] d;
		begin
			d = prefer_later ? (a - b) : (b - a);
			ranks_worse = d[DL_W-1];
		end
	endfunction
endpackage
`default_nettype wire

@@ rtl/cpu_deadline_best_tracker.sv @@
// ----------------------------------------------------------------------------
// cpu_deadline_best_tracker
// per-cpu deadline table with a cached best cpu for push and pull finds
// ----------------------------------------------------------------------------
// in_valid/in_stall take one item: kind, cpu_index, deadline, masks and
// want_mask. out_valid/out_stall give one result per item, in order.
// a two-entry queue sits in front of the execution part, so items are taken
// while a result still waits. a push find with want_mask answered by a free
// cpu, or a mark on a cpu out of range, answers in the cycle after it leaves
// the queue. other items pass ST_RD, ST_FIN_RD, ST_FIN after a cache rebuild
// if needed, which reads the deadline memory one cpu at a time. prefer_later
// is written through cfg_we/cfg_wdata while the block is idle; only the user
// is bound, the block does not enforce it. reset marks all cpus free, clears
// the deadline valid bits and the cache and sets prefer_later to 1, not the
// deadline memory. a stalled result holds; the back part waits for it first.
// ----------------------------------------------------------------------------
`default_nettype none
module cpu_deadline_best_tracker import cdbt_pkg::*; #(
	parameter int unsigned NUM_CPUS = NUM_CPUS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        kind,
	input  wire logic [CPU_W-1:0]  cpu_index,
	input  wire logic [DL_W-1:0]   deadline,
	input  wire logic [MASK_W-1:0] allowed_mask,
	input  wire logic [MASK_W-1:0] active_mask,
	input  wire logic              want_mask,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   found,
	output logic [CPU_W-1:0]       chosen_cpu,
	output logic [MASK_W-1:0]      candidate_mask
);
	logic prefer_later_q;
	logic cmd_valid, cmd_take;
	cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) prefer_later_q <= 1'b1;
		else if (cfg_we) prefer_later_q <= cfg_wdata;
	end

	cdbt_front #(.NUM_CPUS(NUM_CPUS)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .kind, .cpu_index, .deadline,
		.allowed_mask, .active_mask, .want_mask,
		.cmd_valid, .cmd_take, .cmd
	);

	cdbt_back #(.NUM_CPUS(NUM_CPUS)) u_back (
		.clk, .arst_n, .prefer_later(prefer_later_q), .cmd_valid, .cmd_take, .cmd,
		.out_valid, .out_stall, .found, .chosen_cpu, .candidate_mask
	);
endmodule
`default_nettype wire

@@ rtl/cdbt_front.sv @@
// ----------------------------------------------------------------------------
// cdbt_front
// input stage: takes items, classifies them and holds a two-entry queue
// ----------------------------------------------------------------------------
`default_nettype none
module cdbt_front import cdbt_pkg::*; #(
	parameter int unsigned NUM_CPUS = NUM_CPUS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        kind,
	input  wire logic [CPU_W-1:0]  cpu_index,
	input  wire logic [DL_W-1:0]   deadline,
	input  wire logic [MASK_W-1:0] allowed_mask,
	input  wire logic [MASK_W-1:0] active_mask,
	input  wire logic              want_mask,
	output logic                   cmd_valid,
	input  wire logic              cmd_take,
	output cmd_t                   cmd
);
	cmd_t       q_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	logic       push_w;
	cmd_t       nc;

	assign in_stall = (cnt_q == 2'd2);
	assign push_w = in_valid && !in_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = q_q[rd_q];

	always_comb begin
		nc.kind = kind_t'(kind);
		nc.cpu_index = cpu_index;
		nc.deadline = deadline;
		nc.allowed_mask = allowed_mask;
		nc.active_mask = active_mask;
		nc.want_mask = want_mask;
		nc.cpu_ok = ({26'd0, cpu_index} < NUM_CPUS);
	end

	always_ff @(posedge clk) begin
		if (push_w) q_q[wr_q] <= nc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push_w) wr_q <= !wr_q;
			if (cmd_take) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push_w} - {1'b0, cmd_take};
		end
	end
endmodule
`default_nettype wire

@@ rtl/cdbt_back.sv @@
// ----------------------------------------------------------------------------
// cdbt_back
// execution: deadline table, free mask, cache with serial rebuild scan
// ----------------------------------------------------------------------------
`default_nettype none
module cdbt_back import cdbt_pkg::*; #(
	parameter int unsigned NUM_CPUS = NUM_CPUS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              prefer_later,
	input  wire logic              cmd_valid,
	output logic                   cmd_take,
	input  cmd_t                   cmd,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   found,
	output logic [CPU_W-1:0]       chosen_cpu,
	output logic [MASK_W-1:0]      candidate_mask
);
	localparam logic [MASK_W-1:0] SPAN = {MASK_W{1'b1}} >> (MASK_W - NUM_CPUS);
	localparam logic [CPU_W:0] LAST = (CPU_W+1)'(NUM_CPUS - 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_RD, ST_SCAN, ST_SCAN_CMP, ST_POST, ST_FIN_RD, ST_FIN
	} state_t;

	state_t            state_q;
	logic [DL_W-1:0]   dl_mem [NUM_CPUS];
	logic [DL_W-1:0]   rd_q;
	logic [NUM_CPUS-1:0] dvalid_q;
	logic [MASK_W-1:0] free_q;
	logic              cvalid_q, cempty_q;
	logic [CPU_W-1:0]  ccpu_q;
	cmd_t              c_q;
	logic [CPU_W:0]    idx_q;
	logic              have_q;
	logic [DL_W-1:0]   best_q;
	logic [CPU_W-1:0]  bcpu_q;
	logic [MASK_W-1:0] cand_w;
	logic [CPU_W-1:0]  low_w;
	logic [CPU_W-1:0]  ci_w;
	logic [CPU_W-1:0]  sidx_w;
	logic              busy_w;
	logic              early_w;
	logic              ans_w;

	assign cand_w = free_q & cmd.allowed_mask & cmd.active_mask & SPAN;
	assign ci_w = cmd.cpu_index;
	assign sidx_w = idx_q[CPU_W-1:0];
	assign busy_w = !free_q[sidx_w] && dvalid_q[sidx_w];
	assign cmd_take = (state_q == ST_IDLE) && cmd_valid && !(out_valid && out_stall);
	assign early_w = ((cmd.kind == KIND_BUSY || cmd.kind == KIND_FREE) && !cmd.cpu_ok)
		|| (cmd.kind == KIND_PUSH && cmd.want_mask && cand_w != '0);
	assign ans_w = (cmd_take && early_w) || (state_q == ST_FIN);

	always_comb begin
		low_w = '0;
		for (int i = MASK_W-1; i >= 0; i--)
			if (cand_w[i]) low_w = CPU_W'(i);
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_SCAN: rd_q <= dl_mem[sidx_w];
			default: rd_q <= dl_mem[ccpu_q];
		endcase
		if (cmd_take && cmd.kind == KIND_BUSY && cmd.cpu_ok)
			dl_mem[ci_w] <= cmd.deadline;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dvalid_q <= '0;
			free_q <= '1;
			cvalid_q <= 1'b0;
			cempty_q <= 1'b0;
			ccpu_q <= '0;
			out_valid <= 1'b0;
			found <= 1'b0;
			chosen_cpu <= '0;
			candidate_mask <= '0;
			c_q <= '0;
			idx_q <= '0;
			have_q <= 1'b0;
			best_q <= '0;
			bcpu_q <= '0;
		end else begin
			if (ans_w) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						c_q <= cmd;
						if ((cmd.kind == KIND_BUSY || cmd.kind == KIND_FREE)
								&& !cmd.cpu_ok) begin
							found <= 1'b0;
							chosen_cpu <= '0;
							candidate_mask <= '0;
						end else if (cmd.kind == KIND_PUSH && cmd.want_mask
								&& cand_w != '0) begin
							found <= 1'b1;
							chosen_cpu <= low_w;
							candidate_mask <= cand_w;
						end else begin
							if (cmd.kind == KIND_BUSY) begin
								dvalid_q[ci_w] <= 1'b1;
								free_q[ci_w] <= 1'b0;
							end else if (cmd.kind == KIND_FREE) begin
								dvalid_q[ci_w] <= 1'b0;
								free_q[ci_w] <= 1'b1;
							end
							idx_q <= '0;
							have_q <= 1'b0;
							if (!cvalid_q || ((cmd.kind == KIND_BUSY ||
									cmd.kind == KIND_FREE) && !cempty_q &&
									ccpu_q == ci_w))
								state_q <= ST_SCAN;
							else
								state_q <= ST_RD;
						end
					end
				end
				ST_SCAN: state_q <= ST_SCAN_CMP;
				ST_SCAN_CMP: begin
					if (busy_w && (!have_q ||
							ranks_worse(prefer_later, best_q, rd_q))) begin
						have_q <= 1'b1;
						best_q <= rd_q;
						bcpu_q <= sidx_w;
					end
					if (idx_q == LAST) state_q <= ST_POST;
					else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_POST: begin
					cvalid_q <= 1'b1;
					cempty_q <= !have_q;
					ccpu_q <= have_q ? bcpu_q : '0;
					state_q <= ST_RD;
				end
				ST_RD: state_q <= ST_FIN_RD;
				ST_FIN_RD: state_q <= ST_FIN;
				ST_FIN: begin
					found <= 1'b0;
					chosen_cpu <= '0;
					candidate_mask <= '0;
					state_q <= ST_IDLE;
					unique case (c_q.kind)
						KIND_BUSY: begin
							if (!(!cempty_q && dvalid_q[ccpu_q] &&
									ranks_worse(prefer_later, c_q.deadline, rd_q))) begin
								ccpu_q <= c_q.cpu_index;
								cempty_q <= 1'b0;
								cvalid_q <= 1'b1;
							end
						end
						KIND_FREE: ;
						KIND_PULL: begin
							if (!cempty_q) begin
								found <= 1'b1;
								chosen_cpu <= ccpu_q;
							end
						end
						KIND_PUSH: begin
							if (!cempty_q && dvalid_q[ccpu_q] &&
									c_q.allowed_mask[ccpu_q] &&
									ranks_worse(prefer_later, c_q.deadline, rd_q)) begin
								found <= 1'b1;
								chosen_cpu <= ccpu_q;
								if (c_q.want_mask)
									candidate_mask <= MASK_W'(1) << ccpu_q;
							end
						end
						default: ;
					endcase
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
